// ===== rtl/cts_pkg.sv =====
// shared widths, limits and types for the chunk type scanner
package cts_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned MAP_W    = 32;
    localparam int unsigned HIDX_W   = 3;

    // value areas longer than this are clamped
    localparam logic [LEN_W-1:0] MAX_VALUE_BYTES = LEN_W'(2048);
    localparam logic [LEN_W-1:0] HDR_BYTES       = LEN_W'(4);
    localparam logic [LEN_W-1:0] OFFSET_MAX      = '1;

    // types above this share the top map bit
    localparam logic [BYTE_W-1:0] TYPE_LAST_OWN = BYTE_W'(30);
    localparam int unsigned       MAP_OVF_BIT   = 31;

    // position inside a chunk header
    localparam logic [HIDX_W-1:0] HDR_START = HIDX_W'(0);
    localparam logic [HIDX_W-1:0] HDR_FLAGS = HIDX_W'(1);
    localparam logic [HIDX_W-1:0] HDR_LEN_H = HIDX_W'(2);
    localparam logic [HIDX_W-1:0] HDR_LEN_L = HIDX_W'(3);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [MAP_W-1:0]  t_map;

endpackage

// ===== rtl/cts_in_if.sv =====
// input byte channel of the chunk type scanner
interface cts_in_if;
    logic               valid;
    logic               ready;
    cts_pkg::t_byte     data_byte;
    cts_pkg::t_len      value_length;
    logic               last_byte;

    modport source (output valid, output data_byte, output value_length, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input value_length, input last_byte,
                    output ready);
endinterface

// ===== rtl/cts_out_if.sv =====
// result channel of the chunk type scanner
interface cts_out_if;
    logic               valid;
    logic               ready;
    cts_pkg::t_map      type_map;
    logic               target_found;
    cts_pkg::t_len      target_offset;
    logic               malformed;

    modport source (output valid, output type_map, output target_found,
                    output target_offset, output malformed, input ready);
    modport sink   (input valid, input type_map, input target_found,
                    input target_offset, input malformed, output ready);
endinterface

// ===== rtl/chunk_type_scanner.sv =====
// chunk type scanner: walks chunk headers of a packet value area, one byte per transfer
//
// i_in carries one byte of the value area per transfer, with the value length and a
// last-byte mark. o_out carries one result per packet: the map of chunk types seen,
// whether the configured target type was met and at which offset, and a malformed flag.
// i_cfg_wr_en / i_cfg_wr_data write the target type; write it only while no packet is
// in flight.
// Throughput is one byte per cycle while i_in.ready is high: the walk state (offset, header
// position, skip count, map, flags) is updated by a short path from each accepted byte.
// The result is registered and shows on o_out in the cycle after the last byte is taken.
// The output register holds one result; bytes that are not last keep flowing while it
// waits. i_in.ready drops only for a last byte while o_out.valid is high and o_out.ready
// is low, and a result taken in the same cycle frees the register for the next one.
// Synchronous reset clears the walk state, the pending result and the target type
// (to 0). After each last byte the walk state returns to its reset value.
module chunk_type_scanner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cts_in_if.sink              i_in,
    cts_out_if.source           o_out,
    input  logic                i_cfg_wr_en,
    input  cts_pkg::t_byte      i_cfg_wr_data
);

    cts_pkg::t_byte                 r_target_type;

    cts_pkg::t_len                  r_byte_offset,    n_byte_offset;
    logic [cts_pkg::HIDX_W-1:0]     r_header_index,   n_header_index;
    cts_pkg::t_byte                 r_pending_type,   n_pending_type;
    cts_pkg::t_byte                 r_length_high,    n_length_high;
    cts_pkg::t_len                  r_skip_remaining, n_skip_remaining;
    cts_pkg::t_map                  r_seen_map,       n_seen_map;
    logic                           r_found_flag,     n_found_flag;
    cts_pkg::t_len                  r_found_position, n_found_position;
    logic                           r_error_flag,     n_error_flag;

    logic                           r_out_valid;
    cts_pkg::t_map                  r_out_map;
    logic                           r_out_found;
    cts_pkg::t_len                  r_out_offset;
    logic                           r_out_malformed;

    logic                           in_xfer;
    logic                           out_xfer;
    cts_pkg::t_len                  vlen;
    logic                           walking;
    logic                           end_err;
    cts_pkg::t_len                  hdr_len;
    cts_pkg::t_len                  chunk_start;
    logic [cts_pkg::LEN_W:0]        chunk_end;
    logic [cts_pkg::LEN_W:0]        padded;
    cts_pkg::t_map                  type_bit;

    assign in_xfer  = i_in.valid & i_in.ready;
    assign out_xfer = r_out_valid & o_out.ready;
    assign i_in.ready = ~r_out_valid | o_out.ready | ~i_in.last_byte;

    assign vlen = (i_in.value_length > cts_pkg::MAX_VALUE_BYTES) ? cts_pkg::MAX_VALUE_BYTES
                                                                 : i_in.value_length;
    assign walking = ~r_error_flag & (r_byte_offset < vlen);

    // length fields of the header closing on this byte
    assign hdr_len     = {r_length_high, i_in.data_byte};
    assign chunk_start = r_byte_offset - cts_pkg::LEN_W'(3);
    assign chunk_end   = {1'b0, chunk_start} + {1'b0, hdr_len};
    assign padded      = ({1'b0, hdr_len} + (cts_pkg::LEN_W+1)'(3))
                         & ~(cts_pkg::LEN_W+1)'(3);

    always_comb begin
        type_bit = '0;
        if (r_pending_type <= cts_pkg::TYPE_LAST_OWN) begin
            type_bit[r_pending_type[4:0]] = 1'b1;
        end else begin
            type_bit[cts_pkg::MAP_OVF_BIT] = 1'b1;
        end
    end

    always_comb begin
        n_byte_offset    = r_byte_offset;
        n_header_index   = r_header_index;
        n_pending_type   = r_pending_type;
        n_length_high    = r_length_high;
        n_skip_remaining = r_skip_remaining;
        n_seen_map       = r_seen_map;
        n_found_flag     = r_found_flag;
        n_found_position = r_found_position;
        n_error_flag     = r_error_flag;
        end_err          = 1'b0;

        if (walking) begin
            case (r_header_index)
                cts_pkg::HDR_START: begin
                    if (r_skip_remaining == '0) begin
                        n_pending_type = i_in.data_byte;
                        // target match is taken before the length is known
                        if (!r_found_flag && i_in.data_byte == r_target_type) begin
                            n_found_flag     = 1'b1;
                            n_found_position = r_byte_offset;
                        end
                        if ((vlen - r_byte_offset) < cts_pkg::HDR_BYTES) begin
                            n_error_flag = 1'b1;
                        end else begin
                            n_header_index = cts_pkg::HDR_FLAGS;
                        end
                    end else begin
                        n_skip_remaining = r_skip_remaining - cts_pkg::LEN_W'(1);
                    end
                end
                cts_pkg::HDR_FLAGS: begin
                    n_header_index = cts_pkg::HDR_LEN_H;
                end
                cts_pkg::HDR_LEN_H: begin
                    n_length_high  = i_in.data_byte;
                    n_header_index = cts_pkg::HDR_LEN_L;
                end
                default: begin
                    n_header_index = cts_pkg::HDR_START;
                    if (hdr_len < cts_pkg::HDR_BYTES || chunk_end > {1'b0, vlen}) begin
                        n_error_flag = 1'b1;
                    end else begin
                        n_seen_map       = r_seen_map | type_bit;
                        n_skip_remaining = padded[cts_pkg::LEN_W-1:0] - cts_pkg::HDR_BYTES;
                    end
                end
            endcase
        end

        if (r_byte_offset != cts_pkg::OFFSET_MAX) begin
            n_byte_offset = r_byte_offset + cts_pkg::LEN_W'(1);
        end

        // packet ending inside a header is malformed
        end_err = n_error_flag | (n_header_index != cts_pkg::HDR_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_type <= '0;
        end else if (i_cfg_wr_en) begin
            r_target_type <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_xfer && i_in.last_byte)) begin
            r_byte_offset    <= '0;
            r_header_index   <= cts_pkg::HDR_START;
            r_pending_type   <= '0;
            r_length_high    <= '0;
            r_skip_remaining <= '0;
            r_seen_map       <= '0;
            r_found_flag     <= 1'b0;
            r_found_position <= '0;
            r_error_flag     <= 1'b0;
        end else if (in_xfer) begin
            r_byte_offset    <= n_byte_offset;
            r_header_index   <= n_header_index;
            r_pending_type   <= n_pending_type;
            r_length_high    <= n_length_high;
            r_skip_remaining <= n_skip_remaining;
            r_seen_map       <= n_seen_map;
            r_found_flag     <= n_found_flag;
            r_found_position <= n_found_position;
            r_error_flag     <= n_error_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.last_byte) begin
            r_out_map       <= n_seen_map;
            r_out_found     <= n_found_flag;
            r_out_offset    <= n_found_flag ? n_found_position : '0;
            r_out_malformed <= end_err;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.type_map      = r_out_map;
    assign o_out.target_found  = r_out_found;
    assign o_out.target_offset = r_out_offset;
    assign o_out.malformed     = r_out_malformed;

    // walk state starts clean after the last byte of a packet
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.last_byte) |=>
            (r_byte_offset == '0 && r_seen_map == '0 && !r_found_flag && !r_error_flag))
        else $error("walk state not cleared after last byte");

    // a stopped walk stays stopped until the packet ends
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_in.last_byte && r_error_flag) |=> r_error_flag)
        else $error("malformed flag dropped inside a packet");

    // an offset is only reported with a found target
    a_offset_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_offset == '0))
        else $error("target offset reported without target");

    // a result is loaded only by a transfer of a last byte
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_xfer && i_in.last_byte))
        else $error("result appeared without a last byte");

endmodule

// ===== verif/chunk_type_scanner_tb.sv =====
// self-checking testbench for the chunk type scanner: directed packets, then random chunk walks
module chunk_type_scanner_tb;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 4;

    typedef struct packed {
        cts_pkg::t_map  type_map;
        logic           target_found;
        cts_pkg::t_len  target_offset;
        logic           malformed;
    } t_chunk_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    cts_pkg::t_byte i_cfg_wr_data;

    cts_in_if  in_if();
    cts_out_if out_if();

    chunk_type_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // walk state of the predictor
    cts_pkg::t_byte              target_setting;
    cts_pkg::t_len               walk_offset;
    logic [cts_pkg::HIDX_W-1:0]  walk_hidx;
    cts_pkg::t_byte              walk_type;
    cts_pkg::t_byte              walk_len_h;
    cts_pkg::t_len               walk_skip;
    cts_pkg::t_map               walk_map;
    logic                        walk_found;
    cts_pkg::t_len               walk_found_pos;
    logic                        walk_error;

    t_chunk_report due_reports[$];

    // packet being built for transfer
    cts_pkg::t_byte  pkt_bytes[$];
    cts_pkg::t_len   pkt_vlen;
    bit              pkt_vary_len;

    bit          traffic_idle;
    int unsigned error_count = 0;
    int unsigned bytes_sent;
    int unsigned packets_sent;
    int unsigned reports_checked = 0;
    int unsigned quiet_cycles = 0;

    task automatic clear_walk();
        walk_offset    = '0;
        walk_hidx      = cts_pkg::HDR_START;
        walk_type      = '0;
        walk_len_h     = '0;
        walk_skip      = '0;
        walk_map       = '0;
        walk_found     = 1'b0;
        walk_found_pos = '0;
        walk_error     = 1'b0;
    endtask

    // one accepted byte through the chunk walk; a last byte queues the packet report
    task automatic advance_walk(cts_pkg::t_byte data, cts_pkg::t_len vlen_in, logic is_last);
        int unsigned   vlen;
        int unsigned   clen;
        int unsigned   start;
        t_chunk_report rep;
        vlen = (vlen_in > cts_pkg::MAX_VALUE_BYTES) ? 32'(cts_pkg::MAX_VALUE_BYTES)
                                                    : 32'(vlen_in);
        if (!walk_error && walk_offset < vlen) begin
            if (walk_hidx == cts_pkg::HDR_START && walk_skip == 0) begin
                walk_type = data;
                // target match is taken before the length is known
                if (!walk_found && data == target_setting) begin
                    walk_found     = 1'b1;
                    walk_found_pos = walk_offset;
                end
                if (vlen - 32'(walk_offset) < 32'(cts_pkg::HDR_BYTES))
                    walk_error = 1'b1;
                else
                    walk_hidx = cts_pkg::HDR_FLAGS;
            end else if (walk_hidx == cts_pkg::HDR_START) begin
                walk_skip = walk_skip - 1'b1;
            end else if (walk_hidx == cts_pkg::HDR_FLAGS) begin
                walk_hidx = cts_pkg::HDR_LEN_H;
            end else if (walk_hidx == cts_pkg::HDR_LEN_H) begin
                walk_len_h = data;
                walk_hidx  = cts_pkg::HDR_LEN_L;
            end else begin
                clen      = 32'({walk_len_h, data});
                start     = 32'(walk_offset) - 3;
                walk_hidx = cts_pkg::HDR_START;
                if (clen < 32'(cts_pkg::HDR_BYTES) || start + clen > vlen) begin
                    walk_error = 1'b1;
                end else begin
                    if (walk_type <= cts_pkg::TYPE_LAST_OWN)
                        walk_map[walk_type[4:0]] = 1'b1;
                    else
                        walk_map[cts_pkg::MAP_OVF_BIT] = 1'b1;
                    walk_skip = cts_pkg::t_len'(((clen + 3) & ~32'd3) - 4);
                end
            end
        end
        if (walk_offset != cts_pkg::OFFSET_MAX)
            walk_offset = walk_offset + 1'b1;
        if (is_last) begin
            // a header left half read is malformed
            if (!walk_error && walk_hidx != cts_pkg::HDR_START)
                walk_error = 1'b1;
            rep.type_map      = walk_map;
            rep.target_found  = walk_found;
            rep.target_offset = walk_found ? walk_found_pos : cts_pkg::t_len'(0);
            rep.malformed     = walk_error;
            due_reports.push_back(rep);
            clear_walk();
        end
    endtask

    task automatic send_byte(cts_pkg::t_byte data, cts_pkg::t_len vlen, logic is_last);
        int unsigned gap;
        @(negedge i_clk);
        if (traffic_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= data;
        in_if.value_length <= vlen;
        in_if.last_byte    <= is_last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        advance_walk(data, vlen, is_last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        cts_pkg::t_len vlen;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            vlen = pkt_vary_len ? cts_pkg::t_len'($urandom) : pkt_vlen;
            send_byte(pkt_bytes[i], vlen, i == pkt_bytes.size() - 1);
        end
        packets_sent++;
    endtask

    // let every queued report arrive, then wait out DRAIN_CYCLES
    task automatic drain_reports();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_target(cts_pkg::t_byte value);
        drain_reports();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        target_setting = value;
    endtask

    function automatic cts_pkg::t_byte pick_chunk_type();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return target_setting;
        if (r == 2)
            return cts_pkg::t_byte'($urandom_range(31, 255));
        if (r == 3)
            return cts_pkg::t_byte'($urandom_range(30, 31));
        return cts_pkg::t_byte'($urandom_range(0, 30));
    endfunction

    // mostly well-formed chunk sequences, some broken, some plain noise
    task automatic build_packet();
        int unsigned mode;
        int unsigned clen;
        int unsigned padded;
        int unsigned cut;
        int unsigned hdr_pos[$];
        pkt_bytes.delete();
        pkt_vary_len = 1'b0;
        mode = $urandom_range(0, 15);
        if (mode == 0) begin
            repeat ($urandom_range(1, 12)) pkt_bytes.push_back(cts_pkg::t_byte'($urandom));
            pkt_vlen     = cts_pkg::t_len'($urandom);
            pkt_vary_len = 1'($urandom_range(0, 1));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            clen   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 64) : $urandom_range(4, 16);
            padded = (clen + 3) & ~32'd3;
            hdr_pos.push_back(pkt_bytes.size());
            pkt_bytes.push_back(pick_chunk_type());
            pkt_bytes.push_back(cts_pkg::t_byte'($urandom));
            pkt_bytes.push_back(cts_pkg::t_byte'(clen >> 8));
            pkt_bytes.push_back(cts_pkg::t_byte'(clen));
            repeat (padded - 4) pkt_bytes.push_back(cts_pkg::t_byte'($urandom));
        end
        pkt_vlen = cts_pkg::t_len'(pkt_bytes.size());
        case (mode)
            1: begin
                // packet ends early, inside a header or a body
                cut = $urandom_range(1, pkt_bytes.size() - 1);
                pkt_bytes = pkt_bytes[0:cut-1];
            end
            2: pkt_bytes[hdr_pos[$urandom_range(0, hdr_pos.size() - 1)] + $urandom_range(2, 3)]
                   = cts_pkg::t_byte'($urandom);
            3: pkt_vlen = cts_pkg::t_len'($urandom_range(0, pkt_bytes.size() + 8));
            4: repeat ($urandom_range(1, 4)) pkt_bytes.push_back(cts_pkg::t_byte'($urandom));
            5: pkt_vlen = cts_pkg::t_len'($urandom_range(32'(cts_pkg::MAX_VALUE_BYTES) + 1,
                                                         32'hFFFF));
            default: ;
        endcase
    endtask

    function automatic void check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_chunk_report want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual map %0h", $time,
                         out_if.type_map);
                error_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("type_map", out_if.type_map, want.type_map);
                check_field("target_found", 32'(out_if.target_found), 32'(want.target_found));
                check_field("target_offset", 32'(out_if.target_offset),
                            32'(want.target_offset));
                check_field("malformed", 32'(out_if.malformed), 32'(want.malformed));
                reports_checked++;
            end
        end
    end

    // result side back-pressure
    initial begin : result_ready
        int unsigned stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (traffic_idle && $urandom_range(0, 9) == 0) begin
                stall_left   = $urandom_range(1, 17) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d reports still due", $time, due_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_short_and_empty();
        // empty value area: every byte ignored
        pkt_bytes = {8'hFF};
        pkt_vlen  = 16'd0;
        send_packet();
        // type byte with fewer than four bytes left
        pkt_bytes = {8'h00, 8'hAA, 8'h55};
        pkt_vlen  = 16'd3;
        send_packet();
        // length below the header size
        pkt_bytes = {8'h05, 8'h00, 8'h00, 8'h02};
        pkt_vlen  = 16'd4;
        send_packet();
    endtask

    task automatic test_map_extremes();
        // oversize value length is clamped; second body cut short by the last byte
        pkt_bytes = {8'd30, 8'hFF, 8'h00, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04,
                     8'hFF, 8'h00, 8'h00, 8'h08, 8'h5A};
        pkt_vlen  = 16'hFFFF;
        send_packet();
    endtask

    task automatic test_target_before_length();
        set_target(8'd7);
        // target chunk whose length runs past the value area still counts as found
        pkt_bytes = {8'h03, 8'h00, 8'h00, 8'h04, 8'h07, 8'h00, 8'h01, 8'h00};
        pkt_vlen  = 16'd8;
        send_packet();
    endtask

    task automatic test_header_cut();
        pkt_bytes = {8'h01, 8'h00};
        pkt_vlen  = 16'd8;
        send_packet();
    endtask

    task automatic test_ignored_bytes();
        // bytes past the value length are skipped, even when the length field moves
        send_byte(8'h02, 16'd4, 1'b0);
        send_byte(8'h00, 16'd4, 1'b0);
        send_byte(8'h00, 16'd4, 1'b0);
        send_byte(8'h04, 16'd4, 1'b0);
        send_byte(8'h09, 16'd4, 1'b0);
        send_byte(8'h09, 16'd0, 1'b1);
        packets_sent++;
    endtask

    task automatic test_random_traffic(int unsigned goal, bit with_idle);
        int unsigned stop_at;
        traffic_idle = with_idle;
        stop_at      = bytes_sent + goal;
        while (bytes_sent < stop_at) begin
            build_packet();
            send_packet();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.value_length = '0;
        in_if.last_byte    = 1'b0;
        traffic_idle       = 1'b1;
        bytes_sent         = 0;
        packets_sent       = 0;
        target_setting     = '0;
        clear_walk();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_and_empty();
        test_map_extremes();
        test_target_before_length();
        test_header_cut();
        test_ignored_bytes();

        set_target(8'hFF);
        test_random_traffic(250, 1'b1);
        set_target(cts_pkg::t_byte'($urandom_range(0, 30)));
        test_random_traffic(250, 1'b1);
        set_target(8'h00);
        test_random_traffic(150, 1'b1);
        set_target(cts_pkg::t_byte'($urandom));
        test_random_traffic(150, 1'b0);

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("walked %0d bytes in %0d packets, %0d reports checked", bytes_sent,
                 packets_sent, reports_checked);
        $display("covered truncation, bad lengths, clamped and shifting lengths, five targets");
        if (error_count == 0 && due_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
